@@ rtl/qpgd_pkg.sv @@
// ----------------------------------------------------------------------------
// qpgd_pkg
// Shared types and constants for the quad photodiode gesture decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qpgd_pkg;

  localparam int LEVEL_W     = 8;
  localparam int DIR_W       = LEVEL_W + 1;   // difference of two levels
  localparam int TOTAL_W     = DIR_W + 1;     // difference of two directions
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int CODE_W      = 3;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET   = LEVEL_W'(30);
  localparam logic [LEVEL_W-1:0] SENSITIVITY_RESET = LEVEL_W'(10);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_SENSITIVITY = 2'd1
  } cfg_reg_t;

  typedef enum logic [CODE_W-1:0] {
    SWIPE_NONE  = 3'd0,
    SWIPE_UP    = 3'd1,
    SWIPE_DOWN  = 3'd2,
    SWIPE_LEFT  = 3'd3,
    SWIPE_RIGHT = 3'd4
  } gesture_t;

  // One photodiode dataset
  typedef struct packed {
    logic [LEVEL_W-1:0] up;
    logic [LEVEL_W-1:0] down;
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } dataset_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] threshold;
    logic [LEVEL_W-1:0] sensitivity;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/quad_photodiode_gesture_decoder_core.sv @@
// ----------------------------------------------------------------------------
// quad_photodiode_gesture_decoder_core
// Swipe direction decoder for four-channel photodiode datasets.
// ----------------------------------------------------------------------------
// One dataset per clock while out_stall stays low: a dataset is registered on
// input, decoded from that register against the tracked entry/last
// directions, and its gesture code lands in the output register. Every
// dataset yields exactly one gesture code (nonzero only on the departing
// dataset that decides a swipe). Registers are written through cfg_write/
// cfg_index/cfg_data; writes to unknown indexes are dropped.
`default_nettype none

module quad_photodiode_gesture_decoder_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [qpgd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [qpgd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [qpgd_pkg::LEVEL_W-1:0]        up_level,
  input  wire logic [qpgd_pkg::LEVEL_W-1:0]        down_level,
  input  wire logic [qpgd_pkg::LEVEL_W-1:0]        left_level,
  input  wire logic [qpgd_pkg::LEVEL_W-1:0]        right_level,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [qpgd_pkg::CODE_W-1:0]              gesture_code
);
  import qpgd_pkg::*;

  cfg_t     cfg;
  dataset_t in_data, held_data;
  logic     held_valid;
  logic     fire;
  gesture_t code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold   <= THRESHOLD_RESET;
      cfg.sensitivity <= SENSITIVITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD:   cfg.threshold   <= cfg_data[LEVEL_W-1:0];
        REG_SENSITIVITY: cfg.sensitivity <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_data = '{up: up_level, down: down_level, left: left_level, right: right_level};

  // Decode when a dataset is held and the output register is free or draining
  assign fire = held_valid && (!out_valid || !out_stall);

  qpgd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (fire),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  qpgd_decide u_decide (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .data (held_data),
    .cfg  (cfg),
    .code (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      gesture_code <= code;
    end
  end

  // Assertions

  // Input side stalls only when a held dataset cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held_valid && out_valid && out_stall))
    else $error("input stalled without a blocked held dataset");

  // A decoded code reaches the output register unchanged
  a_code_lands: assert property (@(posedge clk) disable iff (rst)
    fire |=> (out_valid && gesture_code == $past(code)))
    else $error("decoded gesture not captured in output register");

  // A transfer out while a dataset is held pulls that dataset forward
  a_drain_refill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && held_valid) |=> out_valid)
    else $error("output register emptied while a dataset was waiting");

  // Only defined gesture codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture_code == SWIPE_NONE || gesture_code == SWIPE_UP ||
                   gesture_code == SWIPE_DOWN || gesture_code == SWIPE_LEFT ||
                   gesture_code == SWIPE_RIGHT))
    else $error("undefined gesture code on output");

endmodule

`default_nettype wire

@@ rtl/qpgd_in_stage.sv @@
// ----------------------------------------------------------------------------
// qpgd_in_stage
// Input register: holds one dataset until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module qpgd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire qpgd_pkg::dataset_t in_data,
  input  wire logic              take,       // decode stage consumes the held dataset
  output logic                   held_valid,
  output qpgd_pkg::dataset_t     held_data
);
  import qpgd_pkg::*;

  // Full and not draining this cycle: hold off the upstream side
  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_data <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/qpgd_decide.sv @@
// ----------------------------------------------------------------------------
// qpgd_decide
// Presence test, direction tracking and swipe decision for one dataset.
// ----------------------------------------------------------------------------
`default_nettype none

module qpgd_decide (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,   // dataset is processed this cycle
  input  wire qpgd_pkg::dataset_t data,
  input  wire qpgd_pkg::cfg_t     cfg,
  output qpgd_pkg::gesture_t      code
);
  import qpgd_pkg::*;

  logic                      awaiting_entry;
  logic signed [DIR_W-1:0]   last_dir_x, last_dir_y;
  logic signed [DIR_W-1:0]   entry_dir_x, entry_dir_y;

  logic                      absent;
  logic                      has_entry;
  logic signed [DIR_W-1:0]   cur_x, cur_y;
  logic signed [TOTAL_W-1:0] total_x, total_y, sens_pos, sens_neg;
  gesture_t                  swipe;

  assign absent = (data.up < cfg.threshold) && (data.down < cfg.threshold) &&
                  (data.left < cfg.threshold) && (data.right < cfg.threshold);

  assign cur_x = $signed({1'b0, data.right}) - $signed({1'b0, data.left});
  assign cur_y = $signed({1'b0, data.up})    - $signed({1'b0, data.down});

  assign has_entry = (entry_dir_x != '0) || (entry_dir_y != '0);

  assign total_x  = TOTAL_W'(entry_dir_x) - TOTAL_W'(last_dir_x);
  assign total_y  = TOTAL_W'(entry_dir_y) - TOTAL_W'(last_dir_y);
  assign sens_pos = $signed({2'b00, cfg.sensitivity});
  assign sens_neg = -sens_pos;

  // Priority: up, down, right, left
  always_comb begin
    if (total_y > sens_pos) begin
      swipe = SWIPE_UP;
    end else if (total_y < sens_neg) begin
      swipe = SWIPE_DOWN;
    end else if (total_x > sens_pos) begin
      swipe = SWIPE_RIGHT;
    end else if (total_x < sens_neg) begin
      swipe = SWIPE_LEFT;
    end else begin
      swipe = SWIPE_NONE;
    end
  end

  assign code = (absent && has_entry) ? swipe : SWIPE_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_entry <= 1'b0;
      last_dir_x     <= '0;
      last_dir_y     <= '0;
      entry_dir_x    <= '0;
      entry_dir_y    <= '0;
    end else if (fire) begin
      if (absent) begin
        awaiting_entry <= 1'b1;
        if (has_entry) begin
          last_dir_x  <= '0;
          last_dir_y  <= '0;
          entry_dir_x <= '0;
          entry_dir_y <= '0;
        end
      end else begin
        last_dir_x <= cur_x;
        last_dir_y <= cur_y;
        if (awaiting_entry) begin
          awaiting_entry <= 1'b0;
          entry_dir_x    <= cur_x;
          entry_dir_y    <= cur_y;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad photodiode gesture decoder core. Datasets
// go in through the valid/stall channel and each one's gesture code is
// predicted by a tracker that mirrors the entry/last direction state. Results
// are compared in order as they leave the core. Runs a directed set of swipes
// and edge cases, then random swipe sequences and noise under several
// threshold/sensitivity settings and idle patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import qpgd_pkg::*;

  // indexes the core has no register behind
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_PRINTED = 40;

  // Tracks the decoder state and holds the gesture codes still to come out.
  class gesture_tracker;
    logic [LEVEL_W-1:0]      threshold;
    logic [LEVEL_W-1:0]      sensitivity;
    logic                    awaiting_entry;
    logic signed [DIR_W-1:0] last_x, last_y, entry_x, entry_y;
    gesture_t                expected_codes[$];
    int                      errors;
    int                      swipe_count[2**CODE_W];

    function new();
      threshold      = THRESHOLD_RESET;
      sensitivity    = SENSITIVITY_RESET;
      awaiting_entry = 1'b0;
      last_x  = '0;
      last_y  = '0;
      entry_x = '0;
      entry_y = '0;
      errors  = 0;
      foreach (swipe_count[i]) swipe_count[i] = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == REG_THRESHOLD) begin
        threshold = value;
      end else if (index == REG_SENSITIVITY) begin
        sensitivity = value;
      end
    endfunction

    function void note_dataset(dataset_t ds);
      logic signed [TOTAL_W-1:0] tx, ty, lim;
      gesture_t code;
      code = SWIPE_NONE;
      if (ds.up < threshold && ds.down < threshold &&
          ds.left < threshold && ds.right < threshold) begin
        awaiting_entry = 1'b1;
        // object left; decide only if an entry direction was latched
        if (entry_x != 0 || entry_y != 0) begin
          tx  = entry_x - last_x;
          ty  = entry_y - last_y;
          lim = $signed({2'b00, sensitivity});
          if (ty > lim) begin
            code = SWIPE_UP;
          end else if (ty < -lim) begin
            code = SWIPE_DOWN;
          end else if (tx > lim) begin
            code = SWIPE_RIGHT;
          end else if (tx < -lim) begin
            code = SWIPE_LEFT;
          end
          last_x  = '0;
          last_y  = '0;
          entry_x = '0;
          entry_y = '0;
        end
      end else begin
        last_x = $signed({1'b0, ds.right}) - $signed({1'b0, ds.left});
        last_y = $signed({1'b0, ds.up}) - $signed({1'b0, ds.down});
        if (awaiting_entry) begin
          awaiting_entry = 1'b0;
          entry_x = last_x;
          entry_y = last_y;
        end
      end
      expected_codes.push_back(code);
    endfunction

    function void compare_code(logic [CODE_W-1:0] got);
      gesture_t want;
      if (expected_codes.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTED)
          $display("%0t: gesture_code transfer with none expected, actual %0d", $time, got);
        return;
      end
      want = expected_codes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_PRINTED)
          $display("%0t: gesture_code mismatch, expected %0d (%s), actual %0d",
                   $time, want, want.name(), got);
      end else begin
        swipe_count[want]++;
      end
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [LEVEL_W-1:0]     up_level, down_level, left_level, right_level;
  logic                   out_valid;
  logic                   out_stall;
  logic [CODE_W-1:0]      gesture_code;

  gesture_tracker tracker = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int sent_items;
  int settings_used;
  int unsigned th_list[PHASE_COUNT]   = '{0, 255, 45, 100, 0, 30};
  int unsigned sens_list[PHASE_COUNT] = '{0, 255, 3, 60, 0, 10};

  quad_photodiode_gesture_decoder_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .up_level     (up_level),
    .down_level   (down_level),
    .left_level   (left_level),
    .right_level  (right_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gesture_code (gesture_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.compare_code(gesture_code);
    end
  end

  function automatic dataset_t levels(int u, int d, int l, int r);
    dataset_t ds;
    ds.up    = LEVEL_W'(u);
    ds.down  = LEVEL_W'(d);
    ds.left  = LEVEL_W'(l);
    ds.right = LEVEL_W'(r);
    return ds;
  endfunction

  // all four channels under the threshold (impossible when it is zero)
  function automatic dataset_t absent_dataset();
    dataset_t ds;
    int unsigned th;
    th = tracker.threshold;
    if (th == 0) begin
      ds = $urandom;
    end else begin
      ds = levels($urandom_range(th - 1), $urandom_range(th - 1),
                  $urandom_range(th - 1), $urandom_range(th - 1));
    end
    return ds;
  endfunction

  function automatic dataset_t present_dataset();
    dataset_t ds;
    logic [LEVEL_W-1:0] lvl;
    ds  = $urandom;
    lvl = LEVEL_W'($urandom_range(255, tracker.threshold));
    case ($urandom_range(3))
      0: ds.up    = lvl;
      1: ds.down  = lvl;
      2: ds.left  = lvl;
      default: ds.right = lvl;
    endcase
    return ds;
  endfunction

  function automatic logic [LEVEL_W-1:0] nudge(logic [LEVEL_W-1:0] v, int span);
    int t;
    t = int'(v) + int'($urandom_range(2 * span)) - span;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return LEVEL_W'(t);
  endfunction

  task automatic send_dataset(dataset_t ds);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    up_level    <= ds.up;
    down_level  <= ds.down;
    left_level  <= ds.left;
    right_level <= ds.right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_dataset(ds);
    sent_items++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.write_reg(index, value);
  endtask

  // stop offering and wait for every outstanding gesture code
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // one or two departures, entry, up to five moves, departure
  task automatic send_swipe();
    dataset_t entry_ds, ds;
    int moves;
    repeat ($urandom_range(2, 1)) send_dataset(absent_dataset());
    entry_ds = present_dataset();
    send_dataset(entry_ds);
    moves = $urandom_range(4);
    repeat (moves) send_dataset(present_dataset());
    if ($urandom_range(2) == 0) begin
      // small motion so the totals land near the sensitivity
      ds = levels(nudge(entry_ds.up, 12), nudge(entry_ds.down, 12),
                  nudge(entry_ds.left, 12), nudge(entry_ds.right, 12));
      send_dataset(ds);
    end
    send_dataset(absent_dataset());
  endtask

  initial begin
    int start;
    int p;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_THRESHOLD;
    cfg_data      = '0;
    in_valid      = 1'b0;
    up_level      = '0;
    down_level    = '0;
    left_level    = '0;
    right_level   = '0;
    out_stall     = 1'b0;
    hold_cycles   = 0;
    sent_items    = 0;
    settings_used = 0;
    send_idle_pct = 18;
    recv_idle_pct = 71;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings (threshold 30, sensitivity 10)
    send_dataset(levels(0, 0, 0, 0));          // departure with nothing latched
    send_dataset(levels(255, 255, 255, 255));  // entry with zero direction
    send_dataset(levels(29, 29, 29, 29));      // departure, zero entry: no decision
    send_dataset(levels(200, 0, 0, 0));
    send_dataset(levels(0, 200, 0, 0));
    send_dataset(levels(0, 0, 0, 0));          // up
    send_dataset(levels(0, 200, 0, 0));
    send_dataset(levels(200, 0, 0, 0));
    send_dataset(levels(0, 0, 0, 0));          // down
    send_dataset(levels(0, 0, 0, 200));
    send_dataset(levels(0, 0, 200, 0));
    send_dataset(levels(0, 0, 0, 0));          // right
    send_dataset(levels(0, 0, 200, 0));
    send_dataset(levels(0, 0, 0, 200));
    send_dataset(levels(0, 0, 0, 0));          // left
    send_dataset(levels(40, 30, 0, 0));
    send_dataset(levels(30, 30, 0, 0));
    send_dataset(levels(0, 0, 0, 0));          // total equals sensitivity: none
    send_dataset(levels(41, 30, 0, 0));
    send_dataset(levels(30, 30, 0, 0));
    send_dataset(levels(0, 0, 0, 0));          // one past sensitivity: up
    send_dataset(levels(255, 0, 255, 0));
    send_dataset(levels(0, 255, 0, 255));
    send_dataset(levels(29, 0, 0, 29));        // both axes at full swing, up wins

    for (p = 0; p < PHASE_COUNT; p++) begin
      send_idle_pct = (p < 2) ? 18 : (p < 4) ? 71 : 0;
      recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 18 : 0;
      if (p == 4) begin
        th_list[p]   = $urandom_range(255);
        sens_list[p] = $urandom_range(255);
      end
      drain();
      write_reg(REG_THRESHOLD, CFG_DATA_W'(th_list[p]));
      write_reg(REG_SENSITIVITY, CFG_DATA_W'(sens_list[p]));
      write_reg(p[0] ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
      settings_used++;
      // back-pressure: receiver holds off while datasets keep coming
      if (p == 4) hold_cycles = HOLD_OFF_CYCLES;
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) begin
        if (sent_items - start >= PHASE_ITEMS / 2 && sent_items - start < PHASE_ITEMS / 2 + 8)
          drain();
        if ($urandom_range(3) == 0) begin
          send_dataset(($urandom_range(1) == 0) ? dataset_t'($urandom) : absent_dataset());
        end else begin
          send_swipe();
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d datasets under %0d register settings, thresholds and %s",
             sent_items, settings_used + 1, "sensitivities at both extremes included");
    $display("Swipes checked: up %0d, down %0d, left %0d, right %0d",
             tracker.swipe_count[SWIPE_UP], tracker.swipe_count[SWIPE_DOWN],
             tracker.swipe_count[SWIPE_LEFT], tracker.swipe_count[SWIPE_RIGHT]);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d gesture codes outstanding", tracker.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
